@@ sv/hrps_pkg.sv @@
// shared types and constants for the hid report priority scheduler
// no dependencies; imported by the controller, datapath and top level

package hrps_pkg;

  // request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_KEY_BYTE = 2'd0,
    REQ_USAGE    = 2'd1,
    REQ_SENT     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCHED = 5'b00010,
    ST_KEY   = 5'b00100,
    ST_CLO   = 5'b01000,
    ST_CHI   = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic key_start;  // begin keyboard report, read byte 0
    logic key_adv;    // byte taken, read next byte
    logic cons_pop;   // pop one usage, read it
    logic sel_cons;   // output from usage queue
    logic sel_hi;     // high byte of usage
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic want_send;  // accepted item calls for a send attempt
    logic can_key;    // transport free and keyboard report pending
    logic can_cons;   // transport free and queue not empty
    logic key_last;   // current keyboard byte is the final one
  } dp_stat_t;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int BYTE_W      = 8;
  localparam int KIDX_W      = 5;
  localparam int USAGE_W     = 16;
  localparam int LEN_CALC_W  = 7;

endpackage

@@ sv/hrps_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies

module hrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/hrps_ctrl.sv @@
// controller state machine for the hid report priority scheduler
// depends on hrps_pkg; drives the datapath through dp_cmd_t

module hrps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  hrps_pkg::dp_stat_t stat,
  output hrps_pkg::dp_cmd_t  cmd
);

  import hrps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.want_send) begin
            state_nxt = ST_SCHED;
          end
        end
      end
      ST_SCHED: begin
        if (stat.can_key) begin
          cmd.key_start = 1'b1;
          state_nxt     = ST_KEY;
        end else if (stat.can_cons) begin
          cmd.cons_pop = 1'b1;
          state_nxt    = ST_CLO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_KEY: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.key_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.key_adv = 1'b1;
          end
        end
      end
      ST_CLO: begin
        out_tvalid   = 1'b1;
        cmd.sel_cons = 1'b1;
        if (out_tready) begin
          state_nxt = ST_CHI;
        end
      end
      ST_CHI: begin
        out_tvalid   = 1'b1;
        cmd.sel_cons = 1'b1;
        cmd.sel_hi   = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/hrps_datapath.sv @@
// datapath: report banks, usage ring queue, scheduler state and output mux
// depends on hrps_pkg and hrps_ram; commanded by hrps_ctrl

module hrps_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int REPORT_MAX  = 29
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hrps_pkg::dp_cmd_t             cmd,
  output hrps_pkg::dp_stat_t            stat,
  input  logic [1:0]                    req_type,
  input  logic [hrps_pkg::BYTE_W-1:0]   key_byte,
  input  logic [hrps_pkg::KIDX_W-1:0]   key_index,
  input  logic                          key_final,
  input  logic [hrps_pkg::USAGE_W-1:0]  usage_code,
  output logic [hrps_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_is_consumer,
  output logic                          out_last
);

  import hrps_pkg::*;

  localparam int IW = (REPORT_MAX > 1) ? $clog2(REPORT_MAX) : 1;
  localparam int LW = $clog2(REPORT_MAX + 1);
  localparam int BANK_DEPTH = 2 << IW;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LEN_CALC_W-1:0] RMAX_C = LEN_CALC_W'(REPORT_MAX);
  localparam logic [QW:0]   QD_C    = (QW+1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QLAST_C = QW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] QFULL_C = FW'(QUEUE_DEPTH);

  logic          live_bank_r, live_bank_nxt;
  logic [LW-1:0] live_len_r,  live_len_nxt;
  logic          pending_r,   pending_nxt;
  logic          busy_r,      busy_nxt;
  logic [QW-1:0] head_r,      head_nxt;
  logic [FW-1:0] fill_r,      fill_nxt;
  logic [IW-1:0] idx_r,       idx_nxt;

  req_t                  req;
  logic                  in_range;
  logic                  q_full;
  logic                  q_push;
  logic [LEN_CALC_W-1:0] kidx_ext;
  logic [LEN_CALC_W-1:0] new_len;
  logic [QW:0]           tail_sum;
  logic [QW-1:0]         tail;
  logic [BYTE_W-1:0]     bank_rdata;
  logic [USAGE_W-1:0]    q_rdata;

  assign req      = req_t'(req_type);
  assign kidx_ext = LEN_CALC_W'(key_index);
  assign in_range = kidx_ext < RMAX_C;
  assign new_len  = in_range ? kidx_ext + LEN_CALC_W'(1) : RMAX_C;
  assign q_full   = (fill_r == QFULL_C);
  assign q_push   = cmd.accept && (req == REQ_USAGE) && !q_full;

  // ring tail, head + fill stays below twice the depth
  assign tail_sum = (QW+1)'(head_r) + (QW+1)'(fill_r);
  assign tail     = (tail_sum >= QD_C) ? QW'(tail_sum - QD_C) : QW'(tail_sum);

  always_comb begin
    stat.want_send = 1'b0;
    stat.can_key   = !busy_r && pending_r;
    stat.can_cons  = !busy_r && (fill_r != '0);
    stat.key_last  = (LEN_CALC_W'(idx_r) + LEN_CALC_W'(1)) == LEN_CALC_W'(live_len_r);
    case (req)
      REQ_KEY_BYTE: stat.want_send = key_final;
      REQ_USAGE:    stat.want_send = !q_full;
      REQ_SENT:     stat.want_send = 1'b1;
      REQ_CLEAR:    stat.want_send = 1'b0;
      default:      stat.want_send = 1'b0;
    endcase
  end

  always_comb begin
    live_bank_nxt = live_bank_r;
    live_len_nxt  = live_len_r;
    pending_nxt   = pending_r;
    busy_nxt      = busy_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    if (cmd.accept) begin
      case (req)
        REQ_KEY_BYTE: begin
          if (key_final) begin
            live_bank_nxt = ~live_bank_r;
            live_len_nxt  = LW'(new_len);
            pending_nxt   = 1'b1;
          end
        end
        REQ_USAGE: begin
          if (!q_full) begin
            fill_nxt = fill_r + FW'(1);
          end
        end
        REQ_SENT: begin
          busy_nxt = 1'b0;
        end
        REQ_CLEAR: begin
          pending_nxt = 1'b0;
          fill_nxt    = '0;
          busy_nxt    = 1'b0;
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
    if (cmd.key_start) begin
      pending_nxt = 1'b0;
      busy_nxt    = 1'b1;
      idx_nxt     = '0;
    end
    if (cmd.key_adv) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (cmd.cons_pop) begin
      busy_nxt = 1'b1;
      fill_nxt = fill_r - FW'(1);
      head_nxt = (head_r == QLAST_C) ? '0 : head_r + QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_bank_r <= 1'b0;
      live_len_r  <= '0;
      pending_r   <= 1'b0;
      busy_r      <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
    end else begin
      live_bank_r <= live_bank_nxt;
      live_len_r  <= live_len_nxt;
      pending_r   <= pending_nxt;
      busy_r      <= busy_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // bank address is {bank, byte index}; writes go to the staging bank
  hrps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_ram (
    .clk   (clk),
    .we    (cmd.accept && (req == REQ_KEY_BYTE) && in_range),
    .waddr ({~live_bank_r, kidx_ext[IW-1:0]}),
    .wdata (key_byte),
    .re    (cmd.key_start || cmd.key_adv),
    .raddr ({live_bank_r, idx_nxt}),
    .rdata (bank_rdata)
  );

  hrps_ram #(
    .WIDTH (USAGE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_push),
    .waddr (tail),
    .wdata (usage_code),
    .re    (cmd.cons_pop),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  always_comb begin
    if (!cmd.sel_cons) begin
      out_byte = bank_rdata;
    end else if (cmd.sel_hi) begin
      out_byte = q_rdata[USAGE_W-1:BYTE_W];
    end else begin
      out_byte = q_rdata[BYTE_W-1:0];
    end
  end

  assign out_is_consumer = cmd.sel_cons;
  assign out_last        = cmd.sel_cons ? cmd.sel_hi : stat.key_last;

endmodule

@@ sv/hid_report_priority_scheduler_top.sv @@
// top level of the hid report priority scheduler
// depends on hrps_pkg, hrps_ctrl, hrps_datapath (which holds two hrps_ram)

// The block takes one request at a time on the in_ stream and hands report
// bytes to the transport on the out_ stream. A keyboard report is staged byte
// by byte in the idle bank; its final byte swaps banks and marks the report
// pending, so the newest complete report wins. Consumer usages enter a ring
// queue of QUEUE_DEPTH entries and are dropped without notice when it is
// full. When the transport is free, a pending keyboard report goes first as
// a run of bytes (tlast on the final one), otherwise one usage goes as two
// bytes, low byte first. The transport stays busy until a "report sent"
// request; "clear" drops the pending report, empties the queue and frees the
// transport. A request that calls for a send passes through a scheduling
// step before any byte is offered. The report bank ram has one registered
// read port and streams one byte per cycle while the transport takes it.
// No new request is taken until the last byte of a report has been
// transferred. No clearing pass is needed after reset.

module hid_report_priority_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,   // usage queue entries, 2 to 256
  parameter int REPORT_MAX  = 29    // keyboard report bytes, 1 to 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // key_byte[7:0], key_index[12:8], usage_code[28:13], zero[31:29]
  input  logic [hrps_pkg::IN_TDATA_W-1:0]       in_tdata,
  // req_type[1:0]
  input  logic [hrps_pkg::IN_TUSER_W-1:0]       in_tuser,
  // key_final
  input  logic                                  in_tlast,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_byte[7:0]
  output logic [hrps_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_is_consumer[0]
  output logic                                  out_tuser,
  // out_last
  output logic                                  out_tlast
);

  import hrps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: sequences accept, schedule and byte transfers
  hrps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: banks, queue, scheduler flags, output byte select
  hrps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .REPORT_MAX  (REPORT_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (in_tuser[1:0]),
    .key_byte        (in_tdata[7:0]),
    .key_index       (in_tdata[12:8]),
    .key_final       (in_tlast),
    .usage_code      (in_tdata[28:13]),
    .out_byte        (out_tdata),
    .out_is_consumer (out_tuser),
    .out_last        (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // one item at a time: no input transfer while a result is offered
  a_no_accept_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is offered");

  // no result is offered right after an accepted request; scheduling or idle comes first
  a_sched_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result offered right after input transfer");

  // the low usage byte is always followed by the high usage byte
  a_usage_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser && !out_tlast)
      |=> (out_tvalid && out_tuser && out_tlast))
    else $error("consumer low byte not followed by high byte");

  // a report ends with a return to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("no return to idle after final byte");
`endif

endmodule
